// File: sv/ssef_pkg.sv
// Shared types, codes and text constants of the event framer.
// Used by ssef_front, ssef_queue, ssef_back and sse_event_framer.
package ssef_pkg;

	// Input action codes
	localparam logic [2:0] ACT_ID          = 3'd0;
	localparam logic [2:0] ACT_NAME        = 3'd1;
	localparam logic [2:0] ACT_DATA        = 3'd2;
	localparam logic [2:0] ACT_COMMENT     = 3'd3;
	localparam logic [2:0] ACT_RETRY       = 3'd4;
	localparam logic [2:0] ACT_FIN_EVENT   = 3'd5;
	localparam logic [2:0] ACT_FIN_COMMENT = 3'd6;

	// Prefix selector codes
	localparam logic [2:0] PFX_NONE    = 3'd0;
	localparam logic [2:0] PFX_ID      = 3'd1;
	localparam logic [2:0] PFX_EVENT   = 3'd2;
	localparam logic [2:0] PFX_RETRY   = 3'd3;
	localparam logic [2:0] PFX_DATA    = 3'd4;
	localparam logic [2:0] PFX_COMMENT = 3'd5;

	// Emission phases, bit positions in the phase mask, lowest goes first
	localparam int PH_PFX  = 0;
	localparam int PH_BODY = 1;
	localparam int PH_DIG  = 2;
	localparam int PH_NL   = 3;
	localparam int PH_END  = 4;
	localparam int PH_N    = 5;

	localparam int DIGITS = 10;
	localparam int DIG_W  = 4 * DIGITS;
	localparam int Q_DEPTH = 2;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// Prefix texts, left aligned in seven byte slots
	localparam logic [55:0] STR_ID      = {"id: ", 24'd0};
	localparam logic [55:0] STR_EVENT   = "event: ";
	localparam logic [55:0] STR_RETRY   = "retry: ";
	localparam logic [55:0] STR_DATA    = {"data: ", 8'd0};
	localparam logic [55:0] STR_COMMENT = {": ", 40'd0};

	typedef struct packed {
		logic [2:0]       pfx_sel;
		logic [PH_N-1:0]  mask;
		logic [7:0]       body;
		logic [DIG_W-1:0] digits;
		logic [3:0]       ndig;
	} cmd_t;

	function automatic logic [55:0] pfx_str(input logic [2:0] sel);
		logic [55:0] s;
		unique case (sel)
			PFX_ID:      s = STR_ID;
			PFX_EVENT:   s = STR_EVENT;
			PFX_RETRY:   s = STR_RETRY;
			PFX_DATA:    s = STR_DATA;
			PFX_COMMENT: s = STR_COMMENT;
			default:     s = '0;
		endcase
		return s;
	endfunction

	// Index of the last prefix byte
	function automatic logic [2:0] pfx_last(input logic [2:0] sel);
		logic [2:0] n;
		unique case (sel)
			PFX_ID:      n = 3'd3;
			PFX_EVENT:   n = 3'd6;
			PFX_RETRY:   n = 3'd6;
			PFX_DATA:    n = 3'd5;
			PFX_COMMENT: n = 3'd1;
			default:     n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] pfx_char(input logic [2:0] sel, input logic [2:0] idx);
		logic [55:0] s;
		s = pfx_str(sel);
		return s[55 - 8 * idx -: 8];
	endfunction

endpackage

// File: sv/ssef_front.sv
// Front end: accepts actions, tracks line state, converts retry values to
// decimal and pushes emission commands. Depends on ssef_pkg.
module ssef_front #(
	parameter int VAL_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        action,
	input  logic [7:0]        text_byte,
	input  logic              field_first,
	input  logic              field_last,
	input  logic [31:0]       retry_ms,
	input  logic              q_full,
	output logic              push,
	output ssef_pkg::cmd_t    push_cmd
);

	localparam int CNT_W = $clog2(VAL_BITS + 1);

	logic                        at_line_start_q;
	logic                        after_cr_q;
	logic                        busy_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [VAL_BITS-1:0]         bin_q;
	logic [ssef_pkg::DIG_W-1:0]  bcd_q;
	logic [ssef_pkg::DIG_W-1:0]  bcd_adj;
	logic [3:0]                  ndig;
	logic                        accept;
	logic                        acc_push;
	logic                        is_crlf;
	logic                        retry_done;
	ssef_pkg::cmd_t              acc_cmd;
	ssef_pkg::cmd_t              retry_cmd;

	assign in_ready   = !busy_q && !q_full;
	assign accept     = in_valid && in_ready;
	assign is_crlf    = (text_byte == ssef_pkg::CH_CR) || (text_byte == ssef_pkg::CH_LF);
	assign retry_done = busy_q && (cnt_q == '0);

	// add 3 to each digit of 5 or more before the shift
	always_comb begin
		logic [3:0] d;
		d = '0;
		bcd_adj = '0;
		for (int k = 0; k < ssef_pkg::DIGITS; k++) begin
			d = bcd_q[4*k +: 4];
			bcd_adj[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	// count of significant digits, at least one
	always_comb begin
		ndig = 4'd1;
		for (int k = 1; k < ssef_pkg::DIGITS; k++) begin
			if (bcd_q[4*k +: 4] != 4'd0) begin
				ndig = 4'(k + 1);
			end
		end
	end

	always_comb begin
		retry_cmd = '0;
		retry_cmd.pfx_sel = ssef_pkg::PFX_RETRY;
		retry_cmd.mask[ssef_pkg::PH_PFX] = 1'b1;
		retry_cmd.mask[ssef_pkg::PH_DIG] = 1'b1;
		retry_cmd.mask[ssef_pkg::PH_NL]  = 1'b1;
		retry_cmd.digits = bcd_q;
		retry_cmd.ndig = ndig;
	end

	always_comb begin
		acc_cmd = '0;
		acc_cmd.ndig = 4'd1;
		unique case (action)
			ssef_pkg::ACT_ID, ssef_pkg::ACT_NAME: begin
				acc_cmd.pfx_sel = !field_first ? ssef_pkg::PFX_NONE :
				                  (action == ssef_pkg::ACT_ID) ? ssef_pkg::PFX_ID :
				                  ssef_pkg::PFX_EVENT;
				acc_cmd.mask[ssef_pkg::PH_PFX]  = field_first;
				acc_cmd.mask[ssef_pkg::PH_BODY] = (text_byte != 8'd0);
				acc_cmd.mask[ssef_pkg::PH_NL]   = field_last;
				acc_cmd.body = is_crlf ? ssef_pkg::CH_SPACE : text_byte;
			end
			ssef_pkg::ACT_DATA, ssef_pkg::ACT_COMMENT: begin
				acc_cmd.pfx_sel = (action == ssef_pkg::ACT_DATA) ? ssef_pkg::PFX_DATA :
				                  ssef_pkg::PFX_COMMENT;
				// drop the LF of a CRLF pair
				if (!(after_cr_q && text_byte == ssef_pkg::CH_LF)) begin
					acc_cmd.mask[ssef_pkg::PH_PFX]  = at_line_start_q;
					acc_cmd.mask[ssef_pkg::PH_BODY] = 1'b1;
				end
				acc_cmd.body = is_crlf ? ssef_pkg::CH_LF : text_byte;
			end
			ssef_pkg::ACT_FIN_EVENT, ssef_pkg::ACT_FIN_COMMENT: begin
				acc_cmd.pfx_sel = (action == ssef_pkg::ACT_FIN_EVENT) ? ssef_pkg::PFX_DATA :
				                  ssef_pkg::PFX_COMMENT;
				acc_cmd.mask[ssef_pkg::PH_PFX] = at_line_start_q;
				acc_cmd.mask[ssef_pkg::PH_NL]  = 1'b1;
				acc_cmd.mask[ssef_pkg::PH_END] = 1'b1;
			end
			default: begin
				// retry goes through the converter, unused code does nothing
			end
		endcase
	end

	assign acc_push = (acc_cmd.mask != '0);
	assign push     = retry_done ? !q_full : (accept && acc_push);
	assign push_cmd = retry_done ? retry_cmd : acc_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q <= 1'b1;
			after_cr_q <= 1'b0;
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				unique case (action)
					ssef_pkg::ACT_DATA, ssef_pkg::ACT_COMMENT: begin
						if (after_cr_q && text_byte == ssef_pkg::CH_LF) begin
							after_cr_q <= 1'b0;
						end else begin
							after_cr_q <= (text_byte == ssef_pkg::CH_CR);
							at_line_start_q <= is_crlf;
						end
					end
					ssef_pkg::ACT_FIN_EVENT, ssef_pkg::ACT_FIN_COMMENT: begin
						at_line_start_q <= 1'b1;
						after_cr_q <= 1'b0;
					end
					ssef_pkg::ACT_RETRY: begin
						busy_q <= 1'b1;
						cnt_q <= CNT_W'(VAL_BITS);
					end
					default: begin
					end
				endcase
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (retry_done && !q_full) begin
				busy_q <= 1'b0;
			end
		end
	end

	// conversion datapath, one binary bit shifted in per cycle
	always_ff @(posedge clk) begin
		if (accept && action == ssef_pkg::ACT_RETRY) begin
			bin_q <= retry_ms[VAL_BITS-1:0];
			bcd_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			bcd_q <= {bcd_adj[ssef_pkg::DIG_W-2:0], bin_q[VAL_BITS-1]};
			bin_q <= {bin_q[VAL_BITS-2:0], 1'b0};
		end
	end

endmodule

// File: sv/ssef_queue.sv
// Short command queue between front and back end.
// Depends on ssef_pkg for the command type and depth.
module ssef_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ssef_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output ssef_pkg::cmd_t    head
);

	localparam int PTR_W = $clog2(ssef_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(ssef_pkg::Q_DEPTH + 1);

	ssef_pkg::cmd_t    mem_q [ssef_pkg::Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full      = (cnt_q == CNT_W'(ssef_pkg::Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/ssef_back.sv
// Back end: walks the phases of the head command and emits one byte per
// cycle into the output register while the receiver takes them. Depends on ssef_pkg.
module ssef_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  ssef_pkg::cmd_t    head,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic [0:0]        m_tuser,
	output logic              m_tlast
);

	logic                        active_q;
	logic [ssef_pkg::PH_N-1:0]   mask_q;
	logic [3:0]                  idx_q;
	logic [ssef_pkg::PH_N-1:0]   cur_mask;
	logic [ssef_pkg::PH_N-1:0]   low;
	logic [ssef_pkg::PH_N-1:0]   nxt_mask;
	logic [ssef_pkg::PH_N-1:0]   nxt_low;
	logic [3:0]                  cur_idx;
	logic [3:0]                  nxt_idx;
	logic [3:0]                  first_dig;
	logic [3:0]                  dig;
	logic                        done_ph;
	logic                        issue;
	logic [7:0]                  byte_nxt;

	assign first_dig = head.ndig - 4'd1;
	assign cur_mask  = active_q ? mask_q : head.mask;
	assign low       = cur_mask & (~cur_mask + 1'b1);
	assign cur_idx   = active_q ? idx_q : (low[ssef_pkg::PH_DIG] ? first_dig : 4'd0);
	assign dig       = head.digits[4*cur_idx +: 4];

	always_comb begin
		priority if (low[ssef_pkg::PH_PFX]) begin
			byte_nxt = ssef_pkg::pfx_char(head.pfx_sel, cur_idx[2:0]);
			done_ph  = (cur_idx[2:0] == ssef_pkg::pfx_last(head.pfx_sel));
		end else if (low[ssef_pkg::PH_BODY]) begin
			byte_nxt = head.body;
			done_ph  = 1'b1;
		end else if (low[ssef_pkg::PH_DIG]) begin
			byte_nxt = ssef_pkg::CH_ZERO + {4'd0, dig};
			done_ph  = (cur_idx == 4'd0);
		end else begin
			byte_nxt = ssef_pkg::CH_LF;
			done_ph  = 1'b1;
		end
	end

	assign nxt_mask = done_ph ? (cur_mask & ~low) : cur_mask;
	assign nxt_low  = nxt_mask & (~nxt_mask + 1'b1);

	always_comb begin
		if (!done_ph) begin
			nxt_idx = low[ssef_pkg::PH_PFX] ? cur_idx + 4'd1 : cur_idx - 4'd1;
		end else begin
			nxt_idx = nxt_low[ssef_pkg::PH_DIG] ? first_dig : 4'd0;
		end
	end

	assign issue = head_valid && (!m_tvalid || m_tready);
	assign pop   = issue && (nxt_mask == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (issue) begin
				active_q <= (nxt_mask != '0);
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			mask_q  <= nxt_mask;
			idx_q   <= nxt_idx;
			m_tdata <= byte_nxt;
			m_tlast <= (nxt_mask == '0);
			m_tuser <= low[ssef_pkg::PH_END];
		end
	end

endmodule

// File: sv/sse_event_framer.sv
// Top level of the event stream framer: front end, command queue, back end.
// Depends on ssef_pkg, ssef_front, ssef_queue and ssef_back.
//
// Encodes event-stream fields into wire text, one output byte per transaction.
// Each input transaction carries an action in s_tuser[2:0]: id byte, event name
// byte, data byte, comment byte, retry value, finish event or finish comment.
// Id and name bytes get "id: " / "event: " before the byte flagged first
// (s_tuser[3]) and a newline after the byte flagged last (s_tlast); NUL is
// dropped and CR or LF turns into a space. Data and comment bytes are split into
// lines ("data: " or ": " sent before each line's first byte), with CRLF and a
// lone CR turned into LF. A finish closes the open line, or sends an empty
// prefixed line, and then the blank line, whose byte carries m_tuser = 1.
// m_tlast marks the final byte produced by one input transaction. An input
// that produces no bytes (dropped NUL, LF of a CRLF pair, unused action code)
// leaves nothing on the output. Timing: the front end takes one transaction
// per cycle while the two-entry command queue has room; a retry holds the
// input while its value passes through the decimal converter, one binary bit
// per cycle, and until its command is pushed. The back end sends one byte per
// cycle while the receiver takes them; an item has 1 to 18 bytes, and that
// output rate sets the sustained throughput. The retry value is taken from
// the low RETRY_BITS bits of its field. Fields must be given in id, event,
// retry, data order; the block does not reorder them.
module sse_event_framer #(
	parameter int RETRY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // text_byte[7:0], retry_ms[39:8]
	input  logic [3:0]  s_tuser,   // action[2:0], field_first[3]
	input  logic        s_tlast,   // field_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic [0:0]  m_tuser,   // message_end[0]
	output logic        m_tlast    // run_last
);

	// the field is 32 bits wide, so wider settings change nothing
	localparam int VAL_BITS = (RETRY_BITS < 32) ? RETRY_BITS : 32;

	logic            q_full;
	logic            q_not_empty;
	logic            push;
	logic            pop;
	ssef_pkg::cmd_t  push_cmd;
	ssef_pkg::cmd_t  head;

	// classify and convert, hold input while converting or queue is full
	ssef_front #(
		.VAL_BITS(VAL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.action     (s_tuser[2:0]),
		.text_byte  (s_tdata[7:0]),
		.field_first(s_tuser[3]),
		.field_last (s_tlast),
		.retry_ms   (s_tdata[39:8]),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// decouple the two ends so each can stall on its own
	ssef_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.head     (head)
	);

	// emit bytes of the head command, advance on each output slot
	ssef_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_not_empty),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: verif/sse_event_framer_checker.sv
// Checker for the event stream framer: watches both stream channels, predicts the wire text.
// Predicts the text of every accepted input transaction and compares each output byte
// against it. Depends on ssef_pkg.
module sse_event_framer_checker #(
	parameter int RETRY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // text_byte[7:0], retry_ms[39:8]
	input  logic [3:0]  s_tuser,   // action[2:0], field_first[3]
	input  logic        s_tlast,   // field_last
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // out_byte[7:0]
	input  logic [0:0]  m_tuser,   // message_end[0]
	input  logic        m_tlast,   // run_last
	output int          errors,
	output int          pending,
	output int          n_in,
	output int          n_out,
	output int          n_msgs
);

	typedef struct {
		logic [7:0] ch;
		logic       run_end;
		logic       msg_end;
	} wire_byte_t;

	wire_byte_t wire_text[$];
	logic       prefix_due;   // next data/comment byte opens a new line
	logic       cr_seen;      // last line byte was CR, swallow a following LF

	function automatic void queue_byte(input logic [7:0] ch, input logic msg_end);
		wire_byte_t nb;
		nb.ch = ch;
		nb.run_end = 1'b0;
		nb.msg_end = msg_end;
		wire_text.insert(wire_text.size(), nb);
	endfunction

	function automatic void queue_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			queue_byte(8'(s[i]), 1'b0);
	endfunction

	// Data and comment bytes: fold CRLF and lone CR into LF, prefix each new line
	function automatic void encode_line_byte(input string pfx, input logic [7:0] b);
		if (cr_seen && b == ssef_pkg::CH_LF) begin
			cr_seen = 1'b0;
			return;
		end
		cr_seen = (b == ssef_pkg::CH_CR);
		if (prefix_due)
			queue_text(pfx);
		if (b == ssef_pkg::CH_CR || b == ssef_pkg::CH_LF) begin
			queue_byte(ssef_pkg::CH_LF, 1'b0);
			prefix_due = 1'b1;
		end else begin
			queue_byte(b, 1'b0);
			prefix_due = 1'b0;
		end
	endfunction

	function automatic void encode_retry(input logic [31:0] r);
		logic [31:0] v;
		logic [3:0]  decimal [ssef_pkg::DIGITS];
		int          n;
		int          i;
		v = r;
		if (RETRY_BITS < 32)
			v = r & ((32'd1 << RETRY_BITS) - 32'd1);
		n = 0;
		do begin
			decimal[n] = 4'(v % 10);
			v = v / 10;
			n++;
		end while (v != 0 && n < ssef_pkg::DIGITS);
		queue_text("retry: ");
		for (i = n - 1; i >= 0; i--)
			queue_byte(ssef_pkg::CH_ZERO + 8'(decimal[i]), 1'b0);
		queue_byte(ssef_pkg::CH_LF, 1'b0);
	endfunction

	function automatic void encode_action(input logic [2:0] act, input logic [7:0] b,
			input logic ff, input logic fl, input logic [31:0] r);
		int start_size;
		start_size = wire_text.size();
		case (act)
			ssef_pkg::ACT_ID, ssef_pkg::ACT_NAME: begin
				if (ff) begin
					if (act == ssef_pkg::ACT_ID)
						queue_text("id: ");
					else
						queue_text("event: ");
				end
				if (b != 8'h00)
					queue_byte((b == ssef_pkg::CH_CR || b == ssef_pkg::CH_LF) ?
						ssef_pkg::CH_SPACE : b, 1'b0);
				if (fl)
					queue_byte(ssef_pkg::CH_LF, 1'b0);
			end
			ssef_pkg::ACT_DATA:    encode_line_byte("data: ", b);
			ssef_pkg::ACT_COMMENT: encode_line_byte(": ", b);
			ssef_pkg::ACT_RETRY:   encode_retry(r);
			ssef_pkg::ACT_FIN_EVENT, ssef_pkg::ACT_FIN_COMMENT: begin
				if (prefix_due) begin
					if (act == ssef_pkg::ACT_FIN_EVENT)
						queue_text("data: ");
					else
						queue_text(": ");
				end
				queue_byte(ssef_pkg::CH_LF, 1'b0);
				queue_byte(ssef_pkg::CH_LF, 1'b1);
				prefix_due = 1'b1;
				cr_seen = 1'b0;
			end
			default: ;
		endcase
		// flag the final byte of this transaction
		if (wire_text.size() > start_size)
			wire_text[wire_text.size() - 1].run_end = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wire_byte_t want;
		if (!arst_n) begin
			prefix_due = 1'b1;
			cr_seen = 1'b0;
			wire_text.delete();
			errors = 0;
			n_in = 0;
			n_out = 0;
			n_msgs = 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				encode_action(s_tuser[2:0], s_tdata[7:0], s_tuser[3], s_tlast, s_tdata[39:8]);
				n_in++;
			end
			if (m_tvalid && m_tready) begin
				n_out++;
				if (m_tuser[0] === 1'b1)
					n_msgs++;
				if (wire_text.size() == 0) begin
					$error("unexpected output byte %02h, nothing pending", m_tdata);
					errors++;
				end else begin
					want = wire_text.pop_front();
					if (m_tdata !== want.ch) begin
						$error("out_byte: expected %02h, got %02h", want.ch, m_tdata);
						errors++;
					end
					if (m_tlast !== want.run_end) begin
						$error("run_last: expected %0b, got %0b", want.run_end, m_tlast);
						errors++;
					end
					if (m_tuser[0] !== want.msg_end) begin
						$error("message_end: expected %0b, got %0b", want.msg_end, m_tuser[0]);
						errors++;
					end
				end
			end
			pending <= wire_text.size();
		end
	end

endmodule

// File: verif/sse_event_framer_tb.sv
// Testbench top for sse_event_framer: clock, reset, stimulus and verdict.
// Depends on ssef_pkg, sse_event_framer and sse_event_framer_checker.
module sse_event_framer_tb;

	localparam int RETRY_BITS     = 32;
	localparam logic [2:0] ACT_UNUSED = 3'd7;   // no meaning, block must ignore it
	localparam int RX_HOLD_CYCLES = 300;        // long enough to back up the command queue
	localparam int TAIL_CYCLES    = 64;         // covers a full retry conversion and output

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;    // text_byte[7:0], retry_ms[39:8]
	logic [3:0]  s_tuser;    // action[2:0], field_first[3]
	logic        s_tlast;    // field_last
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;    // out_byte[7:0]
	logic [0:0]  m_tuser;    // message_end[0]
	logic        m_tlast;    // run_last

	int errors;
	int pending;
	int n_in;
	int n_out;
	int n_msgs;

	int tx_idle_pct;   // chance in percent that the sender idles a given cycle
	int rx_stall_pct;  // chance in percent that the receiver stalls a given cycle
	int rx_hold_seq;   // bump to request one long receiver hold-off
	int items_sent;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sse_event_framer #(.RETRY_BITS(RETRY_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sse_event_framer_checker #(.RETRY_BITS(RETRY_BITS)) chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.pending  (pending),
		.n_in     (n_in),
		.n_out    (n_out),
		.n_msgs   (n_msgs)
	);

	// Receiver: random stalls at the current rate; on request drop tready for a long
	// counted stretch so the block backs up and has to stall its input.
	initial begin : receiver
		int hold_seen;
		int count;
		hold_seen = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (rx_hold_seq != hold_seen) begin
				hold_seen = rx_hold_seq;
				m_tready <= 1'b0;
				for (count = 0; count < RX_HOLD_CYCLES; count++)
					@(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Pick a text byte: mostly printable, with line breaks, NUL and raw bytes mixed in
	function automatic logic [7:0] text_char();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return ssef_pkg::CH_CR;
		if (pick < 16)
			return ssef_pkg::CH_LF;
		if (pick < 20)
			return 8'h00;
		if (pick < 30)
			return 8'($urandom);
		return 8'(32 + $urandom_range(94));
	endfunction

	// Offer one transaction and hold it until the block takes it; idle first at the
	// current sender rate, keeping valid high across back-to-back transactions.
	task automatic send(input logic [2:0] act, input logic [7:0] b, input logic ff,
			input logic fl, input logic [31:0] r);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r, b};
		s_tuser  <= {ff, act};
		s_tlast  <= fl;
		do @(posedge clk); while (!s_tready);
		if (act != ACT_UNUSED)
			items_sent++;
	endtask

	// One id or event-name field, first and last marks on its end bytes
	task automatic send_field(input logic [2:0] act);
		int len;
		int i;
		len = $urandom_range(1, 6);
		for (i = 0; i < len; i++)
			send(act, text_char(), (i == 0), (i == len - 1), $urandom);
	endtask

	// Drop valid and hold off until every expected byte has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin : stimulus
		int          tx_mix [4];
		int          rx_mix [4];
		int          phase;
		int          phase_start;
		int          nbytes;
		logic        as_comment;
		logic [31:0] rv;
		tx_mix = '{0, 65, 0, 31};
		rx_mix = '{0, 0, 65, 31};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_seq = 0;
		items_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Id field: prefix on first byte, NUL with no marks dropped, CR to space,
		// top byte value, LF to space plus newline on the last byte
		send(ssef_pkg::ACT_ID, "a", 1'b1, 1'b0, 32'd0);
		send(ssef_pkg::ACT_ID, 8'h00, 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_ID, ssef_pkg::CH_CR, 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_ID, 8'hFF, 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_ID, ssef_pkg::CH_LF, 1'b0, 1'b1, 32'd0);
		// Name fields: NUL carrying both marks gives prefix and newline only
		send(ssef_pkg::ACT_NAME, 8'h00, 1'b1, 1'b1, 32'd0);
		send(ssef_pkg::ACT_NAME, "m", 1'b1, 1'b1, 32'd0);
		// Retry extremes
		send(ssef_pkg::ACT_RETRY, 8'h00, 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_RETRY, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
		// Data lines: CRLF folds, lone LF, lone CR, NUL passes, marks ignored
		send(ssef_pkg::ACT_DATA, "x", 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_DATA, ssef_pkg::CH_CR, 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_DATA, ssef_pkg::CH_LF, 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_DATA, "y", 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_DATA, ssef_pkg::CH_LF, 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_DATA, ssef_pkg::CH_CR, 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_DATA, "z", 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_DATA, 8'h00, 1'b1, 1'b1, 32'd0);
		send(ssef_pkg::ACT_FIN_EVENT, 8'h00, 1'b0, 1'b0, 32'd0);
		// Finish with no open line sends an empty prefixed line
		send(ssef_pkg::ACT_FIN_COMMENT, 8'h00, 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_FIN_EVENT, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
		// Data and comment mixed on one line
		send(ssef_pkg::ACT_DATA, "a", 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_COMMENT, "b", 1'b0, 1'b0, 32'd0);
		send(ssef_pkg::ACT_FIN_COMMENT, 8'h00, 1'b0, 1'b0, 32'd0);
		// Unused action code with everything set: no output
		send(ACT_UNUSED, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			tx_idle_pct = tx_mix[phase];
			rx_stall_pct = rx_mix[phase];
			// With no idling, stall the receiver for a long stretch while sending on
			if (phase == 0)
				rx_hold_seq++;
			phase_start = items_sent;
			while (items_sent - phase_start < 30) begin
				if ($urandom_range(99) < 20) begin
					// noise: any action, any marks, any value
					send(3'($urandom_range(7)), 8'($urandom), 1'($urandom),
						1'($urandom), $urandom);
				end else begin
					// well-formed message with random content
					as_comment = ($urandom_range(3) == 0);
					if (!as_comment) begin
						if ($urandom_range(1) == 1)
							send_field(ssef_pkg::ACT_ID);
						if ($urandom_range(1) == 1)
							send_field(ssef_pkg::ACT_NAME);
						if ($urandom_range(2) == 0) begin
							case ($urandom_range(3))
								0:       rv = $urandom_range(9);
								1:       rv = $urandom_range(99999);
								2:       rv = 32'hFFFF_FFFF;
								default: rv = $urandom;
							endcase
							send(ssef_pkg::ACT_RETRY, 8'($urandom), 1'($urandom),
								1'($urandom), rv);
						end
					end
					nbytes = $urandom_range(12);
					repeat (nbytes)
						send(as_comment ? ssef_pkg::ACT_COMMENT : ssef_pkg::ACT_DATA,
							text_char(), 1'($urandom), 1'($urandom), $urandom);
					send(as_comment ? ssef_pkg::ACT_FIN_COMMENT : ssef_pkg::ACT_FIN_EVENT,
						8'($urandom), 1'($urandom), 1'($urandom), $urandom);
				end
			end
			// Pause the sender until all output of the phase is out
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d input transactions, %0d output bytes and %0d messages,",
			n_in, n_out, n_msgs);
		$display("over four sender/receiver idle mixes plus one long receiver hold-off.");
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin : watchdog
		#3_200_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sse_event_framer.f
sv/ssef_pkg.sv
sv/ssef_front.sv
sv/ssef_queue.sv
sv/ssef_back.sv
sv/sse_event_framer.sv
verif/sse_event_framer_checker.sv
verif/sse_event_framer_tb.sv
